// File: src/prefix_expression_stack_evaluator_defines.svh
// Assertion macros shared by the prefix expression stack evaluator RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef PREFIX_EXPRESSION_STACK_EVALUATOR_DEFINES_SVH
`define PREFIX_EXPRESSION_STACK_EVALUATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PESE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pese: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PESE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pese: next-cycle check failed");

`endif

// File: src/pese_pkg.sv
// Package for the prefix expression stack evaluator: widths, opcodes, status
// codes, sequencer states, divider interface types and saturation helper.
// Depends on nothing.
package pese_pkg;

   localparam int STACK_DEPTH_DEFAULT = 16;
   localparam int QW        = 32;   // Q16.16 word width
   localparam int FRAC_BITS = 16;
   localparam int OPW       = 3;
   localparam int RESW      = 16;
   localparam int STW       = 3;
   localparam int DIV_STEPS = 32;

   localparam logic [OPW-1:0] OP_PUSH = 3'd0;
   localparam logic [OPW-1:0] OP_ADD  = 3'd1;
   localparam logic [OPW-1:0] OP_SUB  = 3'd2;
   localparam logic [OPW-1:0] OP_MUL  = 3'd3;
   localparam logic [OPW-1:0] OP_DIV  = 3'd4;

   typedef enum logic [STW-1:0] {
      ST_OK        = 3'd0,
      ST_UNDERFLOW = 3'd1,
      ST_OVERFLOW  = 3'd2,
      ST_DIVZERO   = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD_A,
      S_RD_B,
      S_EXEC,
      S_MUL,
      S_DIV,
      S_WRITE,
      S_END
   } state_type;

   typedef struct packed {
      logic          start;
      logic [QW-1:0] num_mag;
      logic [QW-1:0] den_mag;
   } div_req_type;

   typedef struct packed {
      logic          busy;
      logic          done;
      logic          ovf;
      logic [QW-1:0] quot;
   } div_rsp_type;

   // Clamp a wide signed value to the Q16.16 range.
   function automatic logic [QW-1:0] sat_q(input logic signed [63:0] v);
      logic [QW-1:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r = 32'h8000_0000;
      end else begin
         r = v[QW-1:0];
      end
      return r;
   endfunction

endpackage

// File: src/pese_divider.sv
// Iterative unsigned divider for the Q16.16 quotient (num * 2^16) / den,
// one quotient bit per cycle with an early check for quotients of 2^32 and up.
// Depends on pese_pkg.
module pese_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  pese_pkg::div_req_type div_req,
   output pese_pkg::div_rsp_type div_rsp
);
   import pese_pkg::*;

   localparam int CW = $clog2(DIV_STEPS + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [QW:0]   rem_ff, rem_in;
   logic [QW-1:0] shq_ff, shq_in;
   logic [QW-1:0] den_ff, den_in;
   logic [QW:0]   rem_sh;
   logic [QW:0]   rem_diff;

   // Shift-subtract step; the numerator's low bits shift out as quotient bits shift in.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      ovf_in   = ovf_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      shq_in   = shq_ff;
      den_in   = den_ff;
      rem_sh   = {rem_ff[QW-1:0], shq_ff[QW-1]};
      rem_diff = rem_sh - {1'b0, den_ff};
      if (div_req.start) begin
         den_in = div_req.den_mag;
         // The quotient reaches 2^32 exactly when the upper numerator half is not below den.
         if ({{(QW-FRAC_BITS){1'b0}}, div_req.num_mag[QW-1:FRAC_BITS]} >= div_req.den_mag) begin
            ovf_in  = 1'b1;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            ovf_in  = 1'b0;
            busy_in = 1'b1;
            cnt_in  = CW'(DIV_STEPS);
            rem_in  = {{(QW+1-FRAC_BITS){1'b0}}, div_req.num_mag[QW-1:FRAC_BITS]};
            shq_in  = {div_req.num_mag[FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
         end
      end else if (busy_ff) begin
         if (!rem_diff[QW]) begin
            rem_in = rem_diff;
            shq_in = {shq_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            shq_in = {shq_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      ovf_ff <= ovf_in;
      rem_ff <= rem_in;
      shq_ff <= shq_in;
      den_ff <= den_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.ovf  = ovf_ff;
   assign div_rsp.quot = shq_ff;

endmodule

// File: src/prefix_expression_stack_evaluator.sv
// Top level of the prefix expression stack evaluator: token sequencer, operand
// stack memory, saturating arithmetic and result register.
// Depends on pese_pkg, pese_divider and prefix_expression_stack_evaluator_defines.svh.
//
//   Channel  Ports     Moves                              Accepted when
//   input    req_*     one token (opcode, operand, last)  req_tvalid & req_tready
//   result   rsp_*     result integer and status          rsp_tvalid & rsp_tready
//
// A push or an ignored opcode is taken in S_IDLE; an operator passes S_RD_A, S_RD_B,
// S_EXEC, S_MUL or S_DIV (which waits for the one-bit-per-cycle divider) and S_WRITE;
// the last token loads the result in S_END. Operators read the stack memory through
// its single registered read port. reset clears the count, the error and the
// sequencer at once; there is no clearing pass. A stalled result holds in its
// register while tokens still flow; only a second last token waits for it.
`include "prefix_expression_stack_evaluator_defines.svh"

module prefix_expression_stack_evaluator #(
   parameter int STACK_DEPTH = pese_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [pese_pkg::QW-1:0]    req_tdata,   // [31:0] operand_value
   input  logic [pese_pkg::OPW-1:0]   req_tuser,   // [2:0] opcode
   input  logic                       req_tlast,   // last_token
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [pese_pkg::RESW-1:0]  rsp_tdata,   // [15:0] result_integer
   output logic [pese_pkg::STW-1:0]   rsp_tuser    // [2:0] status
);
   import pese_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   status_type       err_ff, err_in;
   logic [QW-1:0]    bottom_ff, bottom_in;
   logic [QW-1:0]    res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RESW-1:0]  rsp_data_ff, rsp_data_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [OPW-1:0]   op_ff;
   logic             last_ff;
   logic [QW-1:0]    a_ff, b_ff;
   logic signed [63:0] prod_ff;

   logic [QW-1:0]    stack_mem [STACK_DEPTH];
   logic [QW-1:0]    rd_data_ff;
   logic             mem_we;
   logic [AW-1:0]    mem_waddr, mem_raddr;
   logic [QW-1:0]    mem_wdata;

   logic             req_accept;
   logic             req_is_oper;
   logic             rsp_free;
   logic [CW-1:0]    cnt_m1, cnt_m2;
   logic [QW:0]      sum_ext, dif_ext;
   logic [QW-1:0]    add_sat, sub_sat;
   logic signed [63:0] prod_adj;
   logic signed [63:0] prod_scaled;
   logic [QW-1:0]    mul_sat;
   logic             div_neg;
   logic signed [63:0] div_signed;
   logic [QW-1:0]    div_sat;
   logic [RESW-1:0]  bottom_int;
   div_req_type      div_req;
   div_rsp_type      div_rsp;

   assign req_accept  = req_tvalid & req_tready;
   assign req_is_oper = (req_tuser >= OP_ADD) && (req_tuser <= OP_DIV);
   assign rsp_free    = !rsp_valid_ff || rsp_tready;
   assign cnt_m1      = count_ff - CW'(1);
   assign cnt_m2      = count_ff - CW'(2);

   // Saturating add and subtract on sign-extended operands.
   assign sum_ext = {a_ff[QW-1], a_ff} + {b_ff[QW-1], b_ff};
   assign dif_ext = {a_ff[QW-1], a_ff} - {b_ff[QW-1], b_ff};
   assign add_sat = (sum_ext[QW] != sum_ext[QW-1]) ?
                    (sum_ext[QW] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum_ext[QW-1:0];
   assign sub_sat = (dif_ext[QW] != dif_ext[QW-1]) ?
                    (dif_ext[QW] ? 32'h8000_0000 : 32'h7FFF_FFFF) : dif_ext[QW-1:0];

   // Product scaled by 2^-16 with truncation toward zero.
   assign prod_adj    = prod_ff + (prod_ff[63] ? 64'sd65535 : 64'sd0);
   assign prod_scaled = prod_adj >>> FRAC_BITS;
   assign mul_sat     = sat_q(prod_scaled);

   // Quotient sign applied to the divider's magnitude, then clamped.
   assign div_neg    = a_ff[QW-1] ^ b_ff[QW-1];
   assign div_signed = div_neg ? -$signed({32'b0, div_rsp.quot})
                               : $signed({32'b0, div_rsp.quot});
   assign div_sat    = div_rsp.ovf ? (div_neg ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                   : sat_q(div_signed);

   // Bottom entry truncated toward zero to an integer.
   assign bottom_int = (bottom_ff[QW-1] && (|bottom_ff[FRAC_BITS-1:0])) ?
                       bottom_ff[QW-1:FRAC_BITS] + RESW'(1) : bottom_ff[QW-1:FRAC_BITS];

   // Divider launch in the execute step; a zero divisor never reaches it.
   assign div_req.start   = (state_ff == S_EXEC) && (op_ff == OP_DIV) && (b_ff != '0);
   assign div_req.num_mag = a_ff[QW-1] ? (~a_ff + 32'd1) : a_ff;
   assign div_req.den_mag = b_ff[QW-1] ? (~b_ff + 32'd1) : b_ff;

   pese_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_is_oper && (count_ff >= CW'(2))) begin
                  state_in = S_RD_A;
               end else if (req_tlast) begin
                  state_in = S_END;
               end
            end
         end
         S_RD_A:  state_in = S_RD_B;
         S_RD_B:  state_in = S_EXEC;
         S_EXEC: begin
            if (op_ff == OP_MUL) begin
               state_in = S_MUL;
            end else if (div_req.start) begin
               state_in = S_DIV;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_MUL:   state_in = S_WRITE;
         S_DIV: begin
            if (div_rsp.done) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: state_in = last_ff ? S_END : S_IDLE;
         S_END: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Sequencer outputs: stack access, count, error, result register.
   always_comb begin
      count_in      = count_ff;
      err_in        = err_ff;
      bottom_in     = bottom_ff;
      res_in        = res_ff;
      mem_we        = 1'b0;
      mem_waddr     = count_ff[AW-1:0];
      mem_wdata     = res_ff;
      mem_raddr     = cnt_m1[AW-1:0];
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_tuser == OP_PUSH) begin
                  if (count_ff >= CW'(STACK_DEPTH)) begin
                     err_in = (err_ff == ST_OK) ? ST_OVERFLOW : err_ff;
                  end else begin
                     mem_we    = 1'b1;
                     mem_wdata = req_tdata;
                     if (count_ff == '0) begin
                        bottom_in = req_tdata;
                     end
                     count_in = count_ff + CW'(1);
                  end
               end else if (req_is_oper && (count_ff < CW'(2))) begin
                  err_in = (err_ff == ST_OK) ? ST_UNDERFLOW : err_ff;
               end
            end
         end
         S_RD_A: begin
            mem_raddr = cnt_m2[AW-1:0];
         end
         S_RD_B: begin
            count_in = cnt_m2;
         end
         S_EXEC: begin
            if (op_ff == OP_ADD) begin
               res_in = add_sat;
            end else if (op_ff == OP_SUB) begin
               res_in = sub_sat;
            end else if ((op_ff == OP_DIV) && (b_ff == '0)) begin
               res_in = '0;
               err_in = (err_ff == ST_OK) ? ST_DIVZERO : err_ff;
            end
         end
         S_MUL: begin
            res_in = mul_sat;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               res_in = div_sat;
            end
         end
         S_WRITE: begin
            mem_we = 1'b1;
            if (count_ff == '0) begin
               bottom_in = res_ff;
            end
            count_in = count_ff + CW'(1);
         end
         S_END: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (err_ff != ST_OK) begin
                  rsp_status_in = err_ff;
                  rsp_data_in   = '0;
               end else if (count_ff == '0) begin
                  rsp_status_in = ST_EMPTY;
                  rsp_data_in   = '0;
               end else begin
                  rsp_status_in = ST_OK;
                  rsp_data_in   = bottom_int;
               end
               count_in = '0;
               err_in   = ST_OK;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: token, operands, product, result, bottom shadow, response.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff   <= req_tuser;
         last_ff <= req_tlast;
      end
      if (state_ff == S_RD_A) begin
         a_ff <= rd_data_ff;
      end
      if (state_ff == S_RD_B) begin
         b_ff <= rd_data_ff;
      end
      if (state_ff == S_EXEC) begin
         prod_ff <= $signed(a_ff) * $signed(b_ff);
      end
      res_ff        <= res_in;
      bottom_ff     <= bottom_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Operand stack memory: one write port, one registered read port.
   // Reads and writes never address the same entry in one step, so they never collide.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= stack_mem[mem_raddr];
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   // Checks on the sequencer, the stack count and the divider handshake.
   `PESE_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(STACK_DEPTH))
   `PESE_ASSERT_IMP(a_read_two, clock, reset, state_ff == S_RD_A, count_ff >= CW'(2))
   `PESE_ASSERT_IMP(a_div_done, clock, reset, div_rsp.done, state_ff == S_DIV)
   `PESE_ASSERT_IMP(a_div_idle, clock, reset, state_ff == S_EXEC, !div_rsp.busy)
   `PESE_ASSERT_NXT(a_rsp_load, clock, reset, (state_ff == S_END) && rsp_free, rsp_valid_ff && (count_ff == '0))

endmodule

// File: test/prefix_expression_stack_evaluator_test.sv
// Self-checking testbench for the prefix expression stack evaluator: tokens
// stream in, and each result is compared with the one that a local stack
// predictor works out. Depends on pese_pkg and the evaluator RTL only.
module prefix_expression_stack_evaluator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import pese_pkg::*;

   localparam int CLOCK_PERIOD  = 10;
   localparam int STACK_ENTRIES = STACK_DEPTH_DEFAULT;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 64;

   // Opcodes that the block leaves unused.
   localparam logic [OPW-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OPW-1:0] OP_SPARE_LAST  = 3'd7;

   localparam longint Q_ONE = 64'sd65536;
   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint Q_MIN = -64'sd2147483648;

   typedef struct {
      logic [RESW-1:0] value;
      status_type      status;
   } expr_result_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [QW-1:0]    req_tdata;    // [31:0] operand_value
   logic [OPW-1:0]   req_tuser;    // [2:0] opcode
   logic             req_tlast;    // last_token
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RESW-1:0]  rsp_tdata;    // [15:0] result_integer
   logic [STW-1:0]   rsp_tuser;    // [2:0] status

   // Predictor state: a private copy of the operand stack.
   logic signed [QW-1:0] model_stack [STACK_ENTRIES];
   int unsigned          model_depth = 0;
   status_type           model_error = ST_OK;
   expr_result_type      pending_results [$];

   int  failures        = 0;
   int  tokens_sent     = 0;
   int  results_checked = 0;
   int  status_seen [5] = '{default: 0};
   int  send_gap_pct    = 23;
   int  ready_stall_pct = 50;
   bit  hold_results_req = 1'b0;

   prefix_expression_stack_evaluator #(
      .STACK_DEPTH(STACK_ENTRIES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Hard stop in case the block hangs.
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("%0t ns: %s", $time, what);
      failures++;
   endtask

   // Only the first error of an expression is kept.
   function automatic void note_error(input status_type code);
      if (model_error == ST_OK) begin
         model_error = code;
      end
   endfunction

   function automatic logic signed [QW-1:0] clamp_q16(input longint v);
      if (v > Q_MAX) begin
         return QW'(Q_MAX);
      end else if (v < Q_MIN) begin
         return QW'(Q_MIN);
      end
      return QW'(v);
   endfunction

   // Applies one accepted token to the predicted stack and, on the last token
   // of an expression, queues the result that the block should give.
   task automatic evaluate_token(input logic [OPW-1:0] op, input logic [QW-1:0] operand,
                                 input logic last);
      longint          a;
      longint          b;
      longint          r;
      expr_result_type outcome;
      if (op == OP_PUSH) begin
         if (model_depth >= STACK_ENTRIES) begin
            note_error(ST_OVERFLOW);
         end else begin
            model_stack[model_depth] = operand;
            model_depth++;
         end
      end else if (op <= OP_DIV) begin
         if (model_depth < 2) begin
            note_error(ST_UNDERFLOW);
         end else begin
            // The top entry is the first operand, the one below it the second.
            a = longint'(model_stack[model_depth - 1]);
            b = longint'(model_stack[model_depth - 2]);
            model_depth -= 2;
            unique case (op)
               OP_ADD: r = a + b;
               OP_SUB: r = a - b;
               OP_MUL: r = (a * b) / Q_ONE;
               default: begin
                  if (b == 0) begin
                     note_error(ST_DIVZERO);
                     r = 0;
                  end else begin
                     r = (a * Q_ONE) / b;
                  end
               end
            endcase
            model_stack[model_depth] = clamp_q16(r);
            model_depth++;
         end
      end

      if (last) begin
         outcome.value = '0;
         if (model_error != ST_OK) begin
            outcome.status = model_error;
         end else if (model_depth == 0) begin
            outcome.status = ST_EMPTY;
         end else begin
            outcome.status = ST_OK;
            outcome.value  = RESW'(longint'(model_stack[0]) / Q_ONE);
         end
         pending_results.insert(pending_results.size(), outcome);
         model_depth = 0;
         model_error = ST_OK;
      end
   endtask

   // Offers one token, waits for its transfer and leaves tvalid high, so that
   // back-to-back tokens never drop it. Called and returns at a falling edge.
   task automatic send_token(input logic [OPW-1:0] op, input logic [QW-1:0] operand,
                             input logic last);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= operand;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      evaluate_token(op, operand, last);
      if (op <= OP_DIV) begin
         tokens_sent++;
      end
      @(negedge clock);
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
   endtask

   // The sender pauses here until every expected result has been seen.
   task automatic wait_results_drained();
      while (pending_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   function automatic logic [QW-1:0] pick_operand();
      case ($urandom_range(9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return '0;
         3, 4, 5: return {16'($urandom_range(400)) - 16'd200, 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   // A well-formed prefix expression with op_count operators, sent right to
   // left; the leftmost token carries tlast.
   task automatic send_expression(input int op_count);
      int pushes_left;
      int ops_left;
      int depth;
      pushes_left = op_count + 1;
      ops_left    = op_count;
      depth       = 0;
      while (pushes_left + ops_left > 0) begin
         if (depth >= 2 && ops_left > 0 && (pushes_left == 0 || $urandom_range(1) == 1)) begin
            ops_left--;
            depth--;
            send_token(OPW'($urandom_range(OP_DIV, OP_ADD)), $urandom,
                       pushes_left + ops_left == 0);
         end else begin
            pushes_left--;
            depth++;
            send_token(OP_PUSH, pick_operand(), pushes_left + ops_left == 0);
         end
      end
   endtask

   // Fills the stack close to or past its depth, then folds part of it.
   task automatic send_deep_stack();
      int pushes;
      int folds;
      pushes = $urandom_range(STACK_ENTRIES + 2, STACK_ENTRIES - 2);
      folds  = $urandom_range(pushes - 1);
      for (int i = 1; i <= pushes; i++) begin
         send_token(OP_PUSH, pick_operand(), folds == 0 && i == pushes);
      end
      for (int i = 1; i <= folds; i++) begin
         send_token(OPW'($urandom_range(OP_DIV, OP_ADD)), $urandom, i == folds);
      end
   endtask

   // Arbitrary tokens, spare opcodes included, that break expressions up.
   task automatic send_noise();
      int count;
      count = $urandom_range(6, 1);
      repeat (count) begin
         send_token(OPW'($urandom), $urandom, $urandom_range(3) == 0);
      end
   endtask

   // All four operators in one expression, with saturating quotients and
   // products: + e (- (* a b) (/ c d)).
   task automatic test_all_operators();
      send_token(OP_PUSH, 32'h0000_0001, 1'b0);
      send_token(OP_PUSH, 32'h7FFF_FFFF, 1'b0);
      send_token(OP_DIV,  32'hFFFF_FFFF, 1'b0);
      send_token(OP_PUSH, 32'h8000_0000, 1'b0);
      send_token(OP_PUSH, 32'h8000_0000, 1'b0);
      send_token(OP_MUL,  32'h0000_0000, 1'b0);
      send_token(OP_SUB,  32'h5555_5555, 1'b0);
      send_token(OP_PUSH, 32'h8000_0000, 1'b0);
      send_token(OP_ADD,  32'hAAAA_AAAA, 1'b1);
      end_burst();
   endtask

   // Two entries left at the end: the bottom one is returned, and a negative
   // fraction truncates towards zero.
   task automatic test_leftover_entries();
      send_token(OP_PUSH, 32'hFFFF_0001, 1'b0);
      send_token(OP_PUSH, 32'h0001_8000, 1'b1);
      end_burst();
   endtask

   // Pushing past the stack depth discards the operand and flags overflow.
   task automatic test_stack_overflow();
      for (int i = 0; i <= STACK_ENTRIES; i++) begin
         send_token(OP_PUSH, i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, i == STACK_ENTRIES);
      end
      end_burst();
   endtask

   // Division by zero comes first, the later underflow is dropped, and a
   // spare opcode in between changes nothing.
   task automatic test_first_error_kept();
      send_token(OP_PUSH,        32'h0000_0000, 1'b0);
      send_token(OP_PUSH,        32'h0005_0000, 1'b0);
      send_token(OP_DIV,         32'h0000_0000, 1'b0);
      send_token(OP_SPARE_FIRST, 32'h1234_5678, 1'b0);
      send_token(OP_SUB,         32'h0000_0000, 1'b1);
      end_burst();
   endtask

   // An operator on an empty stack, then an expression with nothing in it.
   task automatic test_underflow_and_empty();
      send_token(OP_ADD,        32'h0000_0000, 1'b1);
      send_token(OP_SPARE_LAST, 32'hFFFF_FFFF, 1'b1);
      end_burst();
   endtask

   // The result side holds off for a long stretch while short expressions
   // keep coming, so that a second last token has to wait at the input.
   task automatic test_result_backpressure();
      hold_results_req = 1'b1;
      repeat (6) begin
         send_expression($urandom_range(1));
      end
      end_burst();
      wait_results_drained();
   endtask

   task automatic test_random_expressions(input int target, input int gap_pct,
                                          input int stall_pct);
      int first;
      int pick;
      send_gap_pct    = gap_pct;
      ready_stall_pct = stall_pct;
      first           = tokens_sent;
      while (tokens_sent - first < target) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            send_expression($urandom_range(6));
         end else if (pick < 85) begin
            send_deep_stack();
         end else begin
            send_noise();
         end
      end
      end_burst();
      wait_results_drained();
   endtask

   // Result side ready: random stalls, or one long hold-off when requested.
   initial begin
      int held;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_results_req) begin
            rsp_tready <= 1'b0;
            for (held = 1; held < HOLD_CYCLES; held++) begin
               @(negedge clock);
            end
            hold_results_req = 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= ready_stall_pct);
         end
      end
   end

   // Every result transfer is checked against the oldest expectation.
   initial begin
      expr_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            results_checked++;
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result %0d, status %0d",
                                         $signed(rsp_tdata), rsp_tuser));
            end else begin
               want = pending_results.pop_front();
               status_seen[int'(want.status)]++;
               if (rsp_tdata !== want.value) begin
                  report_mismatch($sformatf("result %0d: integer %0d, expected %0d",
                                            results_checked, $signed(rsp_tdata),
                                            $signed(want.value)));
               end
               if (rsp_tuser !== want.status) begin
                  report_mismatch($sformatf("result %0d: status %0d, expected %s",
                                            results_checked, rsp_tuser, want.status.name()));
               end
            end
         end
      end
   end

   initial begin
      int         waited;
      string      tally;
      status_type code;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_PUSH;
      req_tlast  = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_all_operators();
      test_leftover_entries();
      test_stack_overflow();
      test_first_error_kept();
      test_underflow_and_empty();
      wait_results_drained();
      test_result_backpressure();
      test_random_expressions(170, 23, 50);
      test_random_expressions(170, 50, 23);
      test_random_expressions(160, 0, 0);

      // Let the last results come out, then allow for a long divide.
      waited = 0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pending_results.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      end

      tally = "";
      for (int i = 0; i < 5; i++) begin
         code  = status_type'(i);
         tally = {tally, $sformatf(" %s=%0d", code.name(), status_seen[i])};
      end
      $display("Sent %0d operand and operator tokens, checked %0d results.",
               tokens_sent, results_checked);
      $display("Results by status:%s", tally);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+src
src/pese_pkg.sv
src/pese_divider.sv
src/prefix_expression_stack_evaluator.sv
test/prefix_expression_stack_evaluator_test.sv
